[hdl/pdfss_pkg.sv]
// shared types, constants and the target-map function of the pwm duty follower with soft start
// no dependencies; imported by every module of the block
package pdfss_pkg;

    // field and storage widths
    localparam int IN_WIDTH    = 24;
    localparam int COUNT_WIDTH = 24;
    localparam int SUM_WIDTH   = COUNT_WIDTH + 4;
    localparam int DIV_WIDTH   = SUM_WIDTH + 4;
    localparam int PCT_WIDTH   = 7;
    localparam int CFG_WIDTH   = 16;
    localparam int CMP_WIDTH   = 16;
    localparam int STEP_WIDTH  = 10;
    localparam int HOLD_WIDTH  = 3;
    localparam int CNT_WIDTH   = 4;
    localparam int DIVC_WIDTH  = 3;

    // behaviour constants
    localparam int SAMPLE_SPACING = 10;
    localparam int HOLD_TICKS     = 5;
    localparam int ROUND_ADDS     = 8;
    localparam int ROUND_SHIFT    = 3;
    localparam int START_DUTY     = 5;
    localparam int PCT_SCALE      = 100;
    localparam int MAP_LOW        = 12;
    localparam int MAP_HIGH       = 85;
    localparam int MAP_OFFSET     = 22;
    localparam int FULL_LOW       = 1;
    localparam int HOLD_MAX       = 7;
    localparam int CARRIER_RESET  = 1999;
    localparam int QUO_BITS       = 7;

    // reciprocal of 100 for the compare step, exact for every operand from 1 to 65536
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + PCT_SCALE - 1) / PCT_SCALE;
    localparam int RECIP_WIDTH = 2 * (CFG_WIDTH + 1);

    // datapath commands issued by the sequencer
    typedef struct packed {
        logic sample;
        logic shift;
        logic div_init;
        logic div_step;
        logic map;
        logic ramp;
        logic cmp;
        logic load;
    } pdfss_cmd_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic round_full;
    } pdfss_status_t;

    // measured duty to ramp target
    function automatic logic [PCT_WIDTH-1:0] map_target(input logic [PCT_WIDTH-1:0] m);
        logic [PCT_WIDTH-1:0] res;
        begin
            if (m >= PCT_WIDTH'(MAP_LOW) && m <= PCT_WIDTH'(MAP_HIGH))
            begin
                res = (m >> 1) + (m >> 2) + (m >> 3) + PCT_WIDTH'(MAP_OFFSET);
            end
            else if ((m >= PCT_WIDTH'(FULL_LOW) && m <= PCT_WIDTH'(START_DUTY))
                     || m > PCT_WIDTH'(MAP_HIGH))
            begin
                res = PCT_WIDTH'(PCT_SCALE);
            end
            else
            begin
                res = '0;
            end
            return res;
        end
    endfunction

endpackage

[hdl/pdfss_datapath.sv]
// datapath: width sums, shift-subtract duty divider, target map, ramp and compare word
// depends on pdfss_pkg; driven by pdfss_ctrl through pdfss_cmd_t
module pdfss_datapath
    import pdfss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pdfss_cmd_t             cmd,
    output pdfss_status_t          status,
    input  logic [IN_WIDTH-1:0]    high_width,
    input  logic [IN_WIDTH-1:0]    low_width,
    input  logic                   cfg_we,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    output logic [CMP_WIDTH-1:0]   compare_value,
    output logic [PCT_WIDTH-1:0]   running_duty,
    output logic [PCT_WIDTH-1:0]   target_duty,
    output logic [PCT_WIDTH-1:0]   measured_duty,
    output logic                   duty_changed
);

    logic [CFG_WIDTH-1:0]   carrier_reg;
    logic [CNT_WIDTH-1:0]   spacing_reg;
    logic [CNT_WIDTH-1:0]   round_reg;
    logic [SUM_WIDTH-1:0]   high_sum_reg;
    logic [SUM_WIDTH-1:0]   low_sum_reg;
    logic [DIV_WIDTH-1:0]   rem_reg;
    logic [DIV_WIDTH-1:0]   dsh_reg;
    logic [QUO_BITS-1:0]    quo_reg;
    logic                   zero_reg;
    logic [PCT_WIDTH-1:0]   measured_reg;
    logic [PCT_WIDTH-1:0]   target_reg;
    logic [PCT_WIDTH-1:0]   running_reg;
    logic [HOLD_WIDTH-1:0]  hold_reg;
    logic                   changed_reg;
    logic [STEP_WIDTH-1:0]  step_reg;
    logic [CMP_WIDTH-1:0]   compare_reg;

    logic [PCT_WIDTH-1:0]   running_next;
    logic [HOLD_WIDTH-1:0]  hold_next;
    logic                   changed_next;
    logic [PCT_WIDTH-1:0]   measured_next;
    logic [SUM_WIDTH-1:0]   total;
    logic                   rem_ge;
    logic [RECIP_WIDTH-1:0] recip_prod;
    logic [CMP_WIDTH:0]     cmp_prod;

    assign status.round_full = (round_reg == CNT_WIDTH'(ROUND_ADDS));

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_reg <= CFG_WIDTH'(CARRIER_RESET);
        end
        else if (cfg_we)
        begin
            carrier_reg <= cfg_data;
        end
    end

    // sampling and round shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg  <= '0;
            round_reg    <= '0;
            high_sum_reg <= '0;
            low_sum_reg  <= '0;
        end
        else if (cmd.sample)
        begin
            if (spacing_reg >= CNT_WIDTH'(SAMPLE_SPACING))
            begin
                high_sum_reg <= high_sum_reg + SUM_WIDTH'(high_width[COUNT_WIDTH-1:0]);
                low_sum_reg  <= low_sum_reg + SUM_WIDTH'(low_width[COUNT_WIDTH-1:0]);
                round_reg    <= round_reg + 1'b1;
                spacing_reg  <= '0;
            end
            else
            begin
                spacing_reg <= spacing_reg + 1'b1;
            end
        end
        else if (cmd.shift)
        begin
            round_reg    <= '0;
            high_sum_reg <= high_sum_reg >> ROUND_SHIFT;
            low_sum_reg  <= low_sum_reg >> ROUND_SHIFT;
        end
    end

    // divider: one quotient bit a cycle, quotient never above 100 when the width total is nonzero
    assign total  = high_sum_reg + low_sum_reg;
    assign rem_ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg  <= DIV_WIDTH'(high_sum_reg) * DIV_WIDTH'(PCT_SCALE);
            dsh_reg  <= DIV_WIDTH'(total) << (QUO_BITS - 1);
            quo_reg  <= '0;
            zero_reg <= (total == '0);
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[QUO_BITS-2:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign measured_next = zero_reg ? '0 : PCT_WIDTH'(quo_reg);

    // soft-start ramp decision
    always_comb
    begin
        running_next = running_reg;
        hold_next    = hold_reg;
        changed_next = 1'b0;
        if (running_reg != '0)
        begin
            if (running_reg != target_reg)
            begin
                if (hold_reg < HOLD_WIDTH'(HOLD_MAX))
                begin
                    hold_next = hold_reg + 1'b1;
                end
                if (hold_reg > HOLD_WIDTH'(HOLD_TICKS) || hold_reg == HOLD_WIDTH'(HOLD_MAX))
                begin
                    if (running_reg > target_reg)
                    begin
                        running_next = running_reg - 1'b1;
                    end
                    else
                    begin
                        running_next = running_reg + 1'b1;
                    end
                    hold_next    = '0;
                    changed_next = 1'b1;
                end
            end
        end
        else if (target_reg != '0)
        begin
            running_next = PCT_WIDTH'(START_DUTY);
            hold_next    = '0;
            changed_next = 1'b1;
        end
    end

    // compare step as (period+1)/100 by reciprocal
    assign recip_prod = RECIP_WIDTH'({1'b0, carrier_reg} + 1'b1)
                        * RECIP_WIDTH'(RECIP_MULT);
    assign cmp_prod   = (CMP_WIDTH + 1)'(step_reg) * (CMP_WIDTH + 1)'(running_reg);

    // duty state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            measured_reg <= PCT_WIDTH'(10);
            target_reg   <= '0;
            running_reg  <= '0;
            hold_reg     <= '0;
            changed_reg  <= 1'b0;
            compare_reg  <= '0;
        end
        else
        begin
            if (cmd.map)
            begin
                measured_reg <= measured_next;
                target_reg   <= map_target(measured_next);
            end
            if (cmd.ramp)
            begin
                running_reg <= running_next;
                hold_reg    <= hold_next;
                changed_reg <= changed_next;
            end
            if (cmd.cmp && changed_reg)
            begin
                compare_reg <= cmp_prod[CMP_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ramp)
        begin
            step_reg <= recip_prod[RECIP_SHIFT +: STEP_WIDTH];
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            compare_value <= compare_reg;
            running_duty  <= running_reg;
            target_duty   <= target_reg;
            measured_duty <= measured_reg;
            duty_changed  <= changed_reg;
        end
    end

    // round counter never passes the round length
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= CNT_WIDTH'(ROUND_ADDS))
        else $error("round counter past round length");

    // quotient is a percentage when the divider finishes
    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.map && !zero_reg) |-> (quo_reg <= QUO_BITS'(PCT_SCALE)))
        else $error("duty quotient above 100");

    // running duty stays a percentage
    a_running_bound: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg <= PCT_WIDTH'(PCT_SCALE))
        else $error("running duty above 100");

endmodule

[hdl/pdfss_ctrl.sv]
// sequencer of the pwm duty follower: one-hot state machine issuing datapath commands
// depends on pdfss_pkg; owns the input stall and the output valid
module pdfss_ctrl
    import pdfss_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  pdfss_status_t status,
    output pdfss_cmd_t    cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CHECK = 9'b000000010,
        ST_SHIFT = 9'b000000100,
        ST_DINIT = 9'b000001000,
        ST_DIV   = 9'b000010000,
        ST_MAP   = 9'b000100000,
        ST_RAMP  = 9'b001000000,
        ST_CMP   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [DIVC_WIDTH-1:0] div_cnt_reg;
    logic [DIVC_WIDTH-1:0] div_cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  load_ok;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign load_ok   = !out_valid_reg || !out_stall;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.sample = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.round_full ? ST_SHIFT : ST_RAMP;
            end
            ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DIVC_WIDTH'(QUO_BITS - 1))
                begin
                    div_cnt_next = '0;
                    state_next   = ST_MAP;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            ST_MAP:
            begin
                cmd.map    = 1'b1;
                state_next = ST_RAMP;
            end
            ST_RAMP:
            begin
                cmd.ramp   = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set by a load, cleared when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // at most one datapath command a cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    // divider count runs only while dividing
    a_divcnt_state: assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != '0) |-> (state_reg == ST_DIV))
        else $error("divider count outside divide state");

    // a load never overwrites a held beat
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || !out_stall))
        else $error("output beat overwritten while stalled");

    // a load always presents a beat next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid_reg)
        else $error("load without output valid");

endmodule

[hdl/pwm_duty_follower_soft_start.sv]
// top level of the pwm duty follower with soft start
// depends on pdfss_pkg, pdfss_ctrl and pdfss_datapath
//
//  channel | direction | handshake             | beat
//  in      | input     | in_valid / in_stall   | high_width, low_width
//  out     | output    | out_valid / out_stall | compare_value, running_duty, target_duty,
//          |           |                       | measured_duty, duty_changed
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (carrier_period)
//
// a tick passes from accept through the check, ramp and compare states to the output
// register; a tick that closes a round of eight adds also passes the shift, divider
// init, divide and map states, the divider yielding one bit of the 7-bit duty quotient a step.
// the next tick is accepted once the previous one sits in the output register.
// a stalled output beat holds; the sequencer then waits before loading the next.
// reset is asynchronous, active low; cfg_ready is always high.
module pwm_duty_follower_soft_start
    import pdfss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [IN_WIDTH-1:0]  high_width,
    input  logic [IN_WIDTH-1:0]  low_width,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CMP_WIDTH-1:0] compare_value,
    output logic [PCT_WIDTH-1:0] running_duty,
    output logic [PCT_WIDTH-1:0] target_duty,
    output logic [PCT_WIDTH-1:0] measured_duty,
    output logic                 duty_changed,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_WIDTH-1:0] cfg_data
);

    pdfss_cmd_t    cmd;
    pdfss_status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    pdfss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    pdfss_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .high_width    (high_width),
        .low_width     (low_width),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .compare_value (compare_value),
        .running_duty  (running_duty),
        .target_duty   (target_duty),
        .measured_duty (measured_duty),
        .duty_changed  (duty_changed)
    );

endmodule
